// ===== sv/vms_pkg.sv =====
// Shared types, character constants and helpers for the version marker scanner.
// No dependencies; imported by every module of the block.
package vms_pkg;

  localparam int unsigned MaxKeywordBytes = 8;
  localparam int unsigned KwLenWidth      = 4;
  localparam int unsigned QueueDepth      = 4;
  localparam int unsigned QueuePtrWidth   = $clog2(QueueDepth);
  localparam int unsigned QueueCntWidth   = $clog2(QueueDepth + 1);

  // Register indexes on the configuration port
  localparam logic [1:0] RegKeywordA    = 2'd0;
  localparam logic [1:0] RegKeywordALen = 2'd1;
  localparam logic [1:0] RegKeywordB    = 2'd2;
  localparam logic [1:0] RegKeywordBLen = 2'd3;

  // Characters
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChNul       = 8'h00;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChHash      = 8'h23;
  localparam logic [7:0] ChDollar    = 8'h24;
  localparam logic [7:0] ChLParen    = 8'h28;
  localparam logic [7:0] ChRParen    = 8'h29;
  localparam logic [7:0] ChGreater   = 8'h3E;
  localparam logic [7:0] ChAt        = 8'h40;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChPrintLo   = 8'h20;
  localparam logic [7:0] ChPrintHi   = 8'h7E;

  // Emit command passed from the scanner to the emitter
  typedef struct packed {
    logic                  is_kw;   // keyword line header, else a single literal byte
    logic                  use_b;   // keyword b selected
    logic [KwLenWidth-1:0] kw_len;  // effective keyword length, 1..8
    logic [7:0]            lit;     // literal byte
  } vms_cmd_t;

  // Clamp a length register to 1..MaxKeywordBytes
  function automatic logic [KwLenWidth-1:0] eff_len(input logic [KwLenWidth-1:0] len);
    logic [KwLenWidth-1:0] res;
    if (len == '0) begin
      res = KwLenWidth'(1);
    end else if (len > KwLenWidth'(MaxKeywordBytes)) begin
      res = KwLenWidth'(MaxKeywordBytes);
    end else begin
      res = len;
    end
    return res;
  endfunction

  // Byte pos of a keyword word
  function automatic logic [7:0] kw_byte(input logic [63:0] kw, input logic [2:0] pos);
    return kw[{pos, 3'b000} +: 8];
  endfunction

endpackage

// ===== sv/vms_in_if.sv =====
// Input stream channel of the version marker scanner: valid/ready plus one byte.
// No dependencies.
interface vms_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// ===== sv/vms_out_if.sv =====
// Output stream channel of the version marker scanner: valid/ready plus one byte.
// No dependencies.
interface vms_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ===== sv/version_marker_scanner_top.sv =====
// Top level of the version marker scanner: config registers, scanner, queue, emitter.
// Depends on vms_pkg, vms_in_if, vms_out_if, vms_front, vms_queue, vms_back.
//
//  Port     Dir  Protocol      Payload
//  in_i     in   valid/ready   data_byte[7:0], end_of_stream
//  out_o    out  valid/ready   out_byte[7:0], last_of_run
//  psel..   in   APB write/rd  keyword_a @0x00, keyword_a_length @0x08,
//                              keyword_b @0x10, keyword_b_length @0x18
//
// One input byte is taken per cycle while the 4-entry command queue has room.
// The emitter sends one byte per cycle while out_o accepts it: one for a copied byte or newline,
// len+2 (up to 10) for a keyword line, so keyword lines back-pressure the input.
// The first result of a byte passes the command queue and the output register before it is valid.
// Reset is asynchronous, active low; no clearing pass is needed.
module version_marker_scanner_top import vms_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  vms_in_if.sink      in_i,
  vms_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0]           keyword_a_q, keyword_b_q;
  logic [KwLenWidth-1:0] keyword_a_len_q, keyword_b_len_q;
  logic                  cfg_we;
  logic [1:0]            cfg_idx;

  logic     fire, push, pop, full, empty;
  vms_cmd_t push_cmd, head;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keyword_a_q     <= '0;
      keyword_a_len_q <= KwLenWidth'(1);
      keyword_b_q     <= '0;
      keyword_b_len_q <= KwLenWidth'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        RegKeywordA:    keyword_a_q     <= pwdata;
        RegKeywordALen: keyword_a_len_q <= pwdata[KwLenWidth-1:0];
        RegKeywordB:    keyword_b_q     <= pwdata;
        RegKeywordBLen: keyword_b_len_q <= pwdata[KwLenWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegKeywordA:    prdata = keyword_a_q;
      RegKeywordALen: prdata = {{(64-KwLenWidth){1'b0}}, keyword_a_len_q};
      RegKeywordB:    prdata = keyword_b_q;
      default:        prdata = {{(64-KwLenWidth){1'b0}}, keyword_b_len_q};
    endcase
  end

  // Input handshake
  assign in_i.ready = !full;
  assign fire       = in_i.valid && !full;

  vms_front u_front (
    .clk_i,
    .rst_ni,
    .fire_i          (fire),
    .data_byte_i     (in_i.data_byte),
    .end_of_stream_i (in_i.end_of_stream),
    .keyword_a_i     (keyword_a_q),
    .keyword_a_len_i (keyword_a_len_q),
    .keyword_b_i     (keyword_b_q),
    .keyword_b_len_i (keyword_b_len_q),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  vms_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  vms_back u_back (
    .clk_i,
    .rst_ni,
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .keyword_a_i (keyword_a_q),
    .keyword_b_i (keyword_b_q),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_byte_o  (out_o.out_byte),
    .out_last_o  (out_o.last_of_run)
  );

endmodule

// ===== sv/vms_front.sv =====
// Scanner front end: marker state machine, one input byte per cycle while fire_i is high.
// Depends on vms_pkg; pushes emit commands into vms_queue.
module vms_front import vms_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  end_of_stream_i,
  input  logic [63:0]           keyword_a_i,
  input  logic [KwLenWidth-1:0] keyword_a_len_i,
  input  logic [63:0]           keyword_b_i,
  input  logic [KwLenWidth-1:0] keyword_b_len_i,
  output logic                  push_o,
  output vms_cmd_t              cmd_o
);

  localparam logic [2:0] PhIdle    = 3'd0;
  localparam logic [2:0] PhAt      = 3'd1;
  localparam logic [2:0] PhParen   = 3'd2;
  localparam logic [2:0] PhHash    = 3'd3;
  localparam logic [2:0] PhSccs    = 3'd4;
  localparam logic [2:0] PhKwMatch = 3'd5;
  localparam logic [2:0] PhKwCopy  = 3'd6;

  logic [2:0]            phase_q, phase_d;
  logic [KwLenWidth-1:0] pos_q, pos_d;
  logic                  alive_a_q, alive_a_d;
  logic                  alive_b_q, alive_b_d;

  logic [KwLenWidth-1:0] len_a, len_b;
  logic [KwLenWidth:0]   pos_next;
  logic [7:0]            want;
  logic                  hit_a, hit_b, done_a, done_b;
  logic                  reexam, push;
  logic                  c_term, c_print;

  assign len_a    = eff_len(keyword_a_len_i);
  assign len_b    = eff_len(keyword_b_len_i);
  assign pos_next = {1'b0, pos_q} + (KwLenWidth+1)'(1);
  assign hit_a = !end_of_stream_i && alive_a_q && (pos_q < len_a)
               && (data_byte_i == kw_byte(keyword_a_i, pos_q[2:0]));
  assign hit_b = !end_of_stream_i && alive_b_q && (pos_q < len_b)
               && (data_byte_i == kw_byte(keyword_b_i, pos_q[2:0]));
  assign done_a = hit_a && (pos_next == {1'b0, len_a});
  assign done_b = hit_b && (pos_next == {1'b0, len_b});
  assign c_term = end_of_stream_i || data_byte_i == ChNul || data_byte_i == ChQuote
               || data_byte_i == ChGreater || data_byte_i == ChNewline
               || data_byte_i == ChBackslash;
  assign c_print = !end_of_stream_i && data_byte_i >= ChPrintLo && data_byte_i <= ChPrintHi;

  always_comb begin
    unique case (phase_q)
      PhAt:    want = ChLParen;
      PhParen: want = ChHash;
      default: want = ChRParen;
    endcase
  end

  // Next state and emit command
  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    alive_a_d = alive_a_q;
    alive_b_d = alive_b_q;
    reexam    = 1'b0;
    push      = 1'b0;
    cmd_o     = '{is_kw: 1'b0, use_b: 1'b0, kw_len: len_a, lit: data_byte_i};
    if (fire_i) begin
      unique case (phase_q)
        PhAt, PhParen, PhHash: begin
          if (!end_of_stream_i && data_byte_i == want) begin
            if (phase_q == PhHash) begin
              push      = 1'b1;
              cmd_o.lit = ChTab;
              phase_d   = PhSccs;
            end else begin
              phase_d = phase_q + 3'd1;
            end
          end else begin
            reexam = 1'b1;
          end
        end
        PhSccs: begin
          push = 1'b1;
          if (c_term) begin
            cmd_o.lit = ChNewline;
            phase_d   = PhIdle;
          end
        end
        PhKwMatch: begin
          alive_a_d = hit_a;
          alive_b_d = hit_b;
          if (!hit_a && !hit_b) begin
            reexam = 1'b1;
          end else if (done_a || done_b) begin
            // keyword a wins a tie
            push         = 1'b1;
            cmd_o.is_kw  = 1'b1;
            cmd_o.use_b  = !done_a;
            cmd_o.kw_len = done_a ? len_a : len_b;
            phase_d      = PhKwCopy;
            pos_d        = '0;
            alive_a_d    = 1'b0;
            alive_b_d    = 1'b0;
          end else begin
            pos_d = pos_next[KwLenWidth-1:0];
          end
        end
        PhKwCopy: begin
          push = 1'b1;
          if (!c_print) begin
            cmd_o.lit = ChNewline;
            reexam    = 1'b1;
          end
        end
        default: reexam = 1'b1;
      endcase

      // Byte looked at again as an ordinary idle byte
      if (reexam) begin
        phase_d = PhIdle;
        if (!end_of_stream_i) begin
          if (data_byte_i == ChDollar) begin
            phase_d   = PhKwMatch;
            pos_d     = '0;
            alive_a_d = 1'b1;
            alive_b_d = 1'b1;
          end else if (data_byte_i == ChAt) begin
            phase_d = PhAt;
          end
        end
      end
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      pos_q     <= '0;
      alive_a_q <= 1'b0;
      alive_b_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      alive_a_q <= alive_a_d;
      alive_b_q <= alive_b_d;
    end
  end

  // Match position stays inside the longest keyword while matching
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhKwMatch) |-> (pos_q < KwLenWidth'(MaxKeywordBytes)))
    else $error("match position out of range");
  // Keyword matching always has at least one live candidate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhKwMatch) |-> (alive_a_q || alive_b_q))
    else $error("keyword match with no live keyword");

endmodule

// ===== sv/vms_queue.sv =====
// Short command queue between scanner and emitter, flip-flop storage.
// Depends on vms_pkg.
module vms_queue import vms_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  vms_cmd_t push_cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output vms_cmd_t head_o
);

  vms_cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrWidth-1:0] wptr_q, rptr_q;
  logic [QueueCntWidth-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QueueCntWidth'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QueueCntWidth'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QueueCntWidth'(1);
    end
  end

  // Pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QueuePtrWidth'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + QueuePtrWidth'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

// ===== sv/vms_back.sv =====
// Emitter back end: expands queued commands into output bytes, one per cycle while the output is ready.
// Depends on vms_pkg; drains vms_queue into the output register.
module vms_back import vms_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  vms_cmd_t              head_i,
  output logic                  pop_o,
  input  logic [63:0]           keyword_a_i,
  input  logic [63:0]           keyword_b_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [7:0]            out_byte_o,
  output logic                  out_last_o
);

  logic                  out_valid_q, out_valid_d;
  logic [7:0]            out_byte_q;
  logic                  out_last_q;
  logic [KwLenWidth-1:0] pos_q, pos_d;

  logic                  load, last;
  logic [7:0]            next_byte;
  logic [63:0]           kw;
  logic [KwLenWidth-1:0] kw_idx;

  assign load   = (!out_valid_q || out_ready_i) && !empty_i;
  assign kw     = head_i.use_b ? keyword_b_i : keyword_a_i;
  assign kw_idx = pos_q - KwLenWidth'(2);

  // Byte of the current command: the literal, or for a keyword line tab, '$', then the keyword bytes
  always_comb begin
    if (!head_i.is_kw) begin
      next_byte = head_i.lit;
      last      = 1'b1;
    end else begin
      if (pos_q == '0) begin
        next_byte = ChTab;
      end else if (pos_q == KwLenWidth'(1)) begin
        next_byte = ChDollar;
      end else begin
        next_byte = kw_byte(kw, kw_idx[2:0]);
      end
      last = ({1'b0, pos_q} == ({1'b0, head_i.kw_len} + (KwLenWidth+1)'(1)));
    end
  end

  assign pop_o = load && last;

  always_comb begin
    pos_d = pos_q;
    if (load) begin
      pos_d = last ? '0 : pos_q + KwLenWidth'(1);
    end
    out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= next_byte;
      out_last_q <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  // Expansion position never runs past the keyword line header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && head_i.is_kw) |-> ({1'b0, pos_q} <= ({1'b0, head_i.kw_len}
      + (KwLenWidth+1)'(1))))
    else $error("keyword expansion overran");
  // Position returns to zero after each command
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_o |=> (pos_q == '0))
    else $error("position not cleared after command");

endmodule

// ===== verif/vms_scan_checker.sv =====
// Line checker for the version marker scanner: follows register writes, predicts the
// characters each accepted stream byte emits and compares them with the output channel.
// Depends on vms_pkg, vms_in_if and vms_out_if.
module vms_scan_checker
  import vms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  vms_in_if           in_ch,
  vms_out_if          out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned chars_checked_o
);

  // Mismatches beyond this are counted but not printed
  localparam int unsigned MaxReports = 100;

  typedef enum logic [2:0] {
    ScanIdle,
    ScanAt,
    ScanParen,
    ScanHash,
    ScanWhatCopy,
    ScanKwMatch,
    ScanKwCopy
  } scan_state_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } line_char_t;

  // Scanner state as the checker sees it
  scan_state_e scan_st   = ScanIdle;
  logic [3:0]  kw_pos    = '0;
  logic        a_live    = 1'b0;
  logic        b_live    = 1'b0;

  // Shadow copy of the keyword registers
  logic [63:0] kw_a_word = '0;
  logic [63:0] kw_b_word = '0;
  logic [3:0]  kw_a_len  = 4'd1;
  logic [3:0]  kw_b_len  = 4'd1;

  line_char_t  expected_chars[$];
  line_char_t  head;

  task automatic report_mismatch(input string what);
    if (fail_count_o < MaxReports) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
    fail_count_o++;
  endtask

  // Zero counts as one byte, anything past the maximum as the maximum
  function automatic logic [3:0] clamp_len(input logic [3:0] raw);
    if (raw == 4'd0) return 4'd1;
    if (raw > 4'(MaxKeywordBytes)) return 4'(MaxKeywordBytes);
    return raw;
  endfunction

  // Byte that is examined from scratch: only '$' and '@' start something
  task automatic restart_scan(input logic [7:0] c, input logic eos);
    scan_st = ScanIdle;
    if (!eos) begin
      if (c == ChDollar) begin
        scan_st = ScanKwMatch;
        kw_pos  = '0;
        a_live  = 1'b1;
        b_live  = 1'b1;
      end else if (c == ChAt) begin
        scan_st = ScanAt;
      end
    end
  endtask

  // Advance the scanner by one byte and queue the characters it emits
  task automatic predict_byte(input logic [7:0] c, input logic eos);
    logic [7:0]  line_bytes[$];
    logic [7:0]  wanted;
    logic [3:0]  len_a, len_b, pos, kw_len;
    logic        hit_a, hit_b, done_a, done_b;
    logic [63:0] kw;
    int          k;
    case (scan_st)
      ScanAt, ScanParen, ScanHash: begin
        wanted = (scan_st == ScanAt) ? ChLParen : (scan_st == ScanParen) ? ChHash : ChRParen;
        if (!eos && c == wanted) begin
          if (scan_st == ScanHash) begin
            line_bytes.push_back(ChTab);
            scan_st = ScanWhatCopy;
          end else begin
            scan_st = (scan_st == ScanAt) ? ScanParen : ScanHash;
          end
        end else begin
          restart_scan(c, eos);
        end
      end
      ScanWhatCopy: begin
        if (eos || c == ChNul || c == ChQuote || c == ChGreater || c == ChNewline ||
            c == ChBackslash) begin
          line_bytes.push_back(ChNewline);
          scan_st = ScanIdle;
        end else begin
          line_bytes.push_back(c);
        end
      end
      ScanKwMatch: begin
        len_a  = clamp_len(kw_a_len);
        len_b  = clamp_len(kw_b_len);
        pos    = kw_pos;
        hit_a  = !eos && a_live && pos < len_a && c == 8'(kw_a_word >> {pos[2:0], 3'b000});
        hit_b  = !eos && b_live && pos < len_b && c == 8'(kw_b_word >> {pos[2:0], 3'b000});
        done_a = hit_a && (pos + 4'd1 == len_a);
        done_b = hit_b && (pos + 4'd1 == len_b);
        a_live = hit_a;
        b_live = hit_b;
        if (!hit_a && !hit_b) begin
          restart_scan(c, eos);
        end else if (done_a || done_b) begin
          // first keyword takes priority when both finish together
          kw     = done_a ? kw_a_word : kw_b_word;
          kw_len = done_a ? len_a : len_b;
          line_bytes.push_back(ChTab);
          line_bytes.push_back(ChDollar);
          for (k = 0; k < kw_len; k++) begin
            line_bytes.push_back(8'(kw >> (8 * k)));
          end
          scan_st = ScanKwCopy;
          kw_pos  = '0;
          a_live  = 1'b0;
          b_live  = 1'b0;
        end else begin
          kw_pos = pos + 4'd1;
        end
      end
      ScanKwCopy: begin
        if (!eos && c >= ChPrintLo && c <= ChPrintHi) begin
          line_bytes.push_back(c);
        end else begin
          line_bytes.push_back(ChNewline);
          restart_scan(c, eos);
        end
      end
      default: restart_scan(c, eos);
    endcase
    for (k = 0; k < line_bytes.size(); k++) begin
      expected_chars.push_back('{ch: line_bytes[k], last: (k == line_bytes.size() - 1)});
    end
  endtask

  // Watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_st         = ScanIdle;
      kw_pos          = '0;
      a_live          = 1'b0;
      b_live          = 1'b0;
      kw_a_word       = '0;
      kw_b_word       = '0;
      kw_a_len        = 4'd1;
      kw_b_len        = 4'd1;
      expected_chars.delete();
      fail_count_o    = 0;
      chars_checked_o = 0;
      pending_o      <= 0;
    end else begin
      // byte accepted on this edge is scanned with the old register values
      if (in_ch.valid && in_ch.ready) begin
        predict_byte(in_ch.data_byte, in_ch.end_of_stream);
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3])
          RegKeywordA:    kw_a_word = pwdata;
          RegKeywordALen: kw_a_len  = pwdata[3:0];
          RegKeywordB:    kw_b_word = pwdata;
          RegKeywordBLen: kw_b_len  = pwdata[3:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        chars_checked_o++;
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("output char %h with nothing pending", out_ch.out_byte));
        end else begin
          head = expected_chars.pop_front();
          if (out_ch.out_byte !== head.ch) begin
            report_mismatch($sformatf("char %0d: out_byte %h, predicted %h",
                                      chars_checked_o, out_ch.out_byte, head.ch));
          end
          if (out_ch.last_of_run !== head.last) begin
            report_mismatch($sformatf("char %0d: last_of_run %b, predicted %b",
                                      chars_checked_o, out_ch.last_of_run, head.last));
          end
        end
      end
      pending_o <= expected_chars.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Testbench top for the version marker scanner: clock, reset, register setup,
// byte stream stimulus and verdict. Depends on vms_pkg, the channel interfaces,
// vms_scan_checker and the scanner RTL.
module testbench;
  import vms_pkg::*;

  localparam int unsigned CycleLimit    = 200_000;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned BytesPerPhase = 44;
  localparam int unsigned SettleCycles  = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  vms_in_if  in_ch ();
  vms_out_if out_ch ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned chars_checked;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned bytes_sent;
  int unsigned cycle_count;

  // Keyword settings in force, used to build matching stimulus
  logic [63:0] kw_a_word;
  logic [63:0] kw_b_word;
  int unsigned kw_a_eff;
  int unsigned kw_b_eff;

  version_marker_scanner_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  vms_scan_checker u_scan_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .chars_checked_o (chars_checked)
  );

  always #5 clk_i = ~clk_i;

  // Output back-pressure
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // One byte transaction, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= b;
    in_ch.end_of_stream <= eos;
    do @(posedge clk_i); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_byte(s[i], 1'b0);
    end
  endtask

  // Setup and access cycle; psel stays up for a following write
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  // Length writes carry junk in the unused upper bits
  task automatic set_keywords(input logic [63:0] a, input logic [3:0] len_a,
                              input logic [63:0] b, input logic [3:0] len_b);
    logic [63:0] junk_a, junk_b;
    junk_a = {$urandom, $urandom};
    junk_b = {$urandom, $urandom};
    write_reg(RegKeywordA, a);
    write_reg(RegKeywordALen, {junk_a[63:4], len_a});
    write_reg(RegKeywordB, b);
    write_reg(RegKeywordBLen, {junk_b[63:4], len_b});
    psel    <= 1'b0;
    penable <= 1'b0;
    kw_a_word = a;
    kw_b_word = b;
    kw_a_eff  = (len_a == 0) ? 1 : (len_a > MaxKeywordBytes) ? MaxKeywordBytes : len_a;
    kw_b_eff  = (len_b == 0) ? 1 : (len_b > MaxKeywordBytes) ? MaxKeywordBytes : len_b;
  endtask

  // Stop sending and let every predicted character drain
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    int unsigned phase, phase_start, cut, sel, klen, i;
    logic [7:0]  b;
    logic [63:0] kw;

    rst_ni              <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.data_byte     <= '0;
    in_ch.end_of_stream <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: "Id" and the full-length "Revision"
    set_keywords(64'h6449, 4'd2, 64'h6E6F6973_69766552, 4'd8);
    send_text("@(#)");
    send_byte(8'hFF, 1'b0);
    send_byte(ChGreater, 1'b0);
    // keyword copy ended by a non-printable byte
    send_text("$Id");
    send_byte(ChPrintLo, 1'b0);
    send_byte(ChPrintHi, 1'b0);
    send_byte(8'h7F, 1'b0);
    // end of stream in a partial marker
    send_text("@(");
    send_byte(8'h00, 1'b1);
    // broken keyword, the '@' starts a marker, copy cut by end of stream
    send_text("$Re@(#)x");
    send_byte(8'hA5, 1'b1);
    // end of stream while idle
    send_byte(8'h5A, 1'b1);
    wait_idle();

    for (phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: ;
        1: begin
          // identical keywords finish together
          kw = '0;
          for (i = 0; i < 3; i++) begin
            kw[8*i +: 8] = 8'($urandom_range(ChPrintHi, ChPrintLo));
          end
          set_keywords(kw, 4'd3, kw, 4'd3);
        end
        // "Head" finishes while "Header" is still matching
        2: set_keywords(64'h7265_6461_6548, 4'd6, {$urandom, 32'h6461_6548}, 4'd4);
        3: set_keywords({$urandom, $urandom}, 4'd0, {$urandom, $urandom}, 4'd15);
        4: set_keywords('1, 4'd8, '0, 4'd1);
        default: set_keywords({$urandom, $urandom}, 4'($urandom_range(15, 0)),
                              {$urandom, $urandom}, 4'($urandom_range(15, 0)));
      endcase
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 68;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 68;
        end
        default: begin
          send_idle_pct  = 32;
          recv_stall_pct = 32;
        end
      endcase

      phase_start = bytes_sent;
      while (bytes_sent - phase_start < BytesPerPhase) begin
        case ($urandom_range(9, 0))
          0, 1, 2: begin
            // what-string line with random body and terminator
            send_text("@(#)");
            repeat ($urandom_range(6, 0)) begin
              do b = 8'($urandom);
              while (b inside {ChNul, ChQuote, ChGreater, ChNewline, ChBackslash});
              send_byte(b, 1'b0);
            end
            case ($urandom_range(5, 0))
              0: send_byte(ChNul, 1'b0);
              1: send_byte(ChQuote, 1'b0);
              2: send_byte(ChGreater, 1'b0);
              3: send_byte(ChNewline, 1'b0);
              4: send_byte(ChBackslash, 1'b0);
              default: send_byte(8'($urandom), 1'b1);
            endcase
          end
          3, 4, 5, 6: begin
            // keyword line, now and then cut short by a stray byte
            sel  = $urandom_range(1, 0);
            kw   = sel ? kw_b_word : kw_a_word;
            klen = sel ? kw_b_eff : kw_a_eff;
            send_byte(ChDollar, 1'b0);
            if ($urandom_range(4, 0) == 0) begin
              cut = $urandom_range(klen - 1, 0);
              for (i = 0; i < cut; i++) begin
                send_byte(kw[8*i +: 8], 1'b0);
              end
              send_byte(8'($urandom), 1'b0);
            end else begin
              for (i = 0; i < klen; i++) begin
                send_byte(kw[8*i +: 8], 1'b0);
              end
              repeat ($urandom_range(5, 0)) begin
                send_byte(8'($urandom_range(ChPrintHi, ChPrintLo)), 1'b0);
              end
              case ($urandom_range(2, 0))
                0: send_byte(8'($urandom_range(31, 0)), 1'b0);
                1: send_byte(8'($urandom_range(255, 127)), 1'b0);
                default: send_byte(8'($urandom), 1'b1);
              endcase
            end
          end
          7: begin
            // partial what marker broken by a random byte
            cut = $urandom_range(3, 1);
            send_byte(ChAt, 1'b0);
            if (cut > 1) begin
              send_byte(ChLParen, 1'b0);
            end
            if (cut > 2) begin
              send_byte(ChHash, 1'b0);
            end
            send_byte(8'($urandom), 1'b0);
          end
          8: begin
            repeat ($urandom_range(4, 1)) begin
              send_byte(8'($urandom), $urandom_range(7, 0) == 0);
            end
          end
          default: send_byte(8'($urandom), 1'b1);
        endcase
      end
      send_byte(8'($urandom), 1'b1);
      wait_idle();
    end

    $display("Run covered %0d stream bytes under %0d keyword settings and four flow modes,",
             bytes_sent, NumPhases);
    $display("with %0d emitted characters compared against the prediction.", chars_checked);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== version_marker_scanner_top.f =====
sv/vms_pkg.sv
sv/vms_in_if.sv
sv/vms_out_if.sv
sv/vms_front.sv
sv/vms_queue.sv
sv/vms_back.sv
sv/version_marker_scanner_top.sv
verif/vms_scan_checker.sv
verif/testbench.sv
